FILE: rtl/alux_pkg.sv
package alux_pkg;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRATION_TIME = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_GAIN = 1'd1;

  // Integration time codes
  localparam logic [1:0] ITIME_13MS = 2'd0;
  localparam logic [1:0] ITIME_101MS = 2'd1;

  // Region codes
  localparam logic [2:0] REGION_0 = 3'd0;
  localparam logic [2:0] REGION_1 = 3'd1;
  localparam logic [2:0] REGION_2 = 3'd2;
  localparam logic [2:0] REGION_3 = 3'd3;
  localparam logic [2:0] REGION_NONE = 3'd4;

  // Coefficients scaled by 100000
  localparam logic [11:0] C0_B = 12'd3040;
  localparam logic [12:0] C0_P = 13'd6200;
  localparam logic [11:0] C1_B = 12'd2240;
  localparam logic [11:0] C1_I = 12'd3100;
  localparam logic [11:0] C2_B = 12'd1280;
  localparam logic [11:0] C2_I = 12'd1530;
  localparam logic [11:0] C3_B = 12'd146;
  localparam logic [11:0] C3_I = 12'd112;

  // Count scale numerators
  localparam logic [12:0] NUM_13MS = 13'd500;
  localparam logic [12:0] NUM_101MS = 13'd250;
  localparam logic [12:0] NUM_402MS = 13'd1;

  // Final divisors: 100000 * time denominator, times 2^16 for region 0
  localparam int unsigned DEN_W = 39;
  localparam logic [DEN_W-1:0] DEN_13MS = 39'd1700000;
  localparam logic [DEN_W-1:0] DEN_101MS = 39'd6300000;
  localparam logic [DEN_W-1:0] DEN_402MS = 39'd100000;

  localparam int unsigned LUX_W = 32;

endpackage

FILE: rtl/alux_sample_if.sv
interface alux_sample_if;
  logic valid;
  logic ready;
  logic [15:0] broadband_count;
  logic [15:0] infrared_count;

  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink (input valid, input broadband_count, input infrared_count, output ready);
endinterface

FILE: rtl/alux_result_if.sv
interface alux_result_if;
  logic valid;
  logic ready;
  logic [31:0] lux_value;
  logic [2:0] region;

  modport source (output valid, output lux_value, output region, input ready);
  modport sink (input valid, input lux_value, input region, output ready);
endinterface

FILE: rtl/ambient_light_lux_calc.sv
// Two-channel lux calculator, fully pipelined.
// Throughput: one request per cycle; the pipeline holds only while the
// two-entry output buffer is full.
// Reset (rst, synchronous): pipeline empty, integration_time 1, high_gain 0.
module ambient_light_lux_calc #(
  parameter int unsigned POWER_TABLE_DEPTH = 64,
  parameter int unsigned LUX_FRACTION_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic write_enable,
  input  logic [alux_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [alux_pkg::CFG_DATA_W-1:0] write_data,
  alux_sample_if.sink   sample,
  alux_result_if.source result
);

  localparam int unsigned QW1 = $clog2(POWER_TABLE_DEPTH+1) + 16;
  localparam int unsigned NW1 = QW1 + 16;
  localparam int unsigned PW1 = 35;
  localparam int unsigned DW2 = alux_pkg::DEN_W;
  localparam int unsigned NW2 = 32 + DW2;
  localparam int unsigned NUMW = 58 + LUX_FRACTION_BITS;
  localparam int unsigned CW = (NUMW > NW2) ? NUMW : NW2;

  // configuration registers
  logic [1:0] integration_time;
  logic       high_gain;
  always_ff @(posedge clk) begin
    if (rst) begin
      integration_time <= 2'd1;
      high_gain <= 1'b0;
    end else if (write_enable) begin
      unique case (reg_index)
        alux_pkg::REG_INTEGRATION_TIME: integration_time <= write_data[1:0];
        alux_pkg::REG_HIGH_GAIN:        high_gain <= write_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic full;
  assign en = !full;
  assign sample.ready = en;

  // S0: input register
  logic        v0;
  logic [15:0] b0, ir0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= sample.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= sample.broadband_count;
      ir0 <= sample.infrared_count;
    end
  end

  // S1: ratio band by exact integer compares
  logic [2:0]  region_c;
  always_comb begin
    if (b0 == 16'd0) begin
      region_c = alux_pkg::REGION_NONE;
    end else if ({ir0, 1'b0} <= {1'b0, b0}) begin
      region_c = alux_pkg::REGION_0;
    end else if (23'(ir0) * 23'd100 <= 23'(b0) * 23'd61) begin
      region_c = alux_pkg::REGION_1;
    end else if (19'(ir0) * 19'd5 <= 19'(b0) * 19'd4) begin
      region_c = alux_pkg::REGION_2;
    end else if (20'(ir0) * 20'd10 <= 20'(b0) * 20'd13) begin
      region_c = alux_pkg::REGION_3;
    end else begin
      region_c = alux_pkg::REGION_NONE;
    end
  end

  logic        v1;
  logic [2:0]  region1;
  logic [15:0] b1, ir1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      region1 <= region_c;
      b1 <= b0;
      ir1 <= ir0;
    end
  end

  // ratio position 2*r*DEPTH in Q.16
  logic [NW1-1:0] pos_num;
  assign pos_num = (NW1'(ir1) * NW1'(2 * POWER_TABLE_DEPTH)) << 16;

  logic           dv1_valid;
  logic [QW1-1:0] pos;
  logic [PW1-1:0] dv1_pay;
  alux_div #(.QW(QW1), .DW(16), .PW(PW1)) u_ratio_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .num(pos_num), .den(b1), .in_pay({region1, b1, ir1}),
    .out_valid(dv1_valid), .quot(pos), .out_pay(dv1_pay)
  );

  logic           pw_valid;
  logic [16:0]    pwr;
  logic [PW1-1:0] pw_pay;
  alux_power #(.DEPTH(POWER_TABLE_DEPTH), .PW(PW1)) u_power (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv1_valid), .pos(pos), .in_pay(dv1_pay),
    .out_valid(pw_valid), .pwr(pwr), .out_pay(pw_pay)
  );

  logic [2:0]  region_p;
  logic [15:0] b_p, ir_p;
  assign {region_p, b_p, ir_p} = pw_pay;

  // S2: linear bands and coefficient times power term
  logic [27:0] lin_add, lin_sub;
  always_comb begin
    case (region_p)
      alux_pkg::REGION_1: begin
        lin_add = 28'(alux_pkg::C1_B) * 28'(b_p);
        lin_sub = 28'(alux_pkg::C1_I) * 28'(ir_p);
      end
      alux_pkg::REGION_2: begin
        lin_add = 28'(alux_pkg::C2_B) * 28'(b_p);
        lin_sub = 28'(alux_pkg::C2_I) * 28'(ir_p);
      end
      default: begin
        lin_add = 28'(alux_pkg::C3_B) * 28'(b_p);
        lin_sub = 28'(alux_pkg::C3_I) * 28'(ir_p);
      end
    endcase
  end

  logic        v2, v3, v4, v5, v6;
  logic [2:0]  region2, region3, region4, region5, region6;
  logic [15:0] b2, b3;
  logic [27:0] dlin2, dlin3;
  logic [29:0] m6200;
  logic [45:0] prod0;
  logic [43:0] diff4;
  logic [56:0] value5;
  logic [DW2-1:0] den5, den6;
  logic [NW2-1:0] num6;
  logic        sat6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v2 <= pw_valid;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // S4 difference for band 0, clamped at zero
  logic [45:0] add0;
  assign add0 = 46'(28'(alux_pkg::C0_B) * 28'(b3)) << 16;

  // S5 scale factor and divisor
  logic [12:0]    num_s;
  logic [DW2-1:0] den_s;
  always_comb begin
    case (integration_time)
      alux_pkg::ITIME_13MS: begin
        num_s = alux_pkg::NUM_13MS;
        den_s = alux_pkg::DEN_13MS;
      end
      alux_pkg::ITIME_101MS: begin
        num_s = alux_pkg::NUM_101MS;
        den_s = alux_pkg::DEN_101MS;
      end
      default: begin
        num_s = alux_pkg::NUM_402MS;
        den_s = alux_pkg::DEN_402MS;
      end
    endcase
    if (!high_gain) num_s = 13'(num_s << 4);
    if (region4 == alux_pkg::REGION_0) den_s = DW2'(den_s << 16);
  end

  // S6 rounding offset and saturation test
  logic [CW-1:0] num_r;
  logic [CW-1:0] den_top;
  assign num_r = CW'({value5, {LUX_FRACTION_BITS{1'b0}}}) + CW'(den5 >> 1);
  assign den_top = CW'({den5, 32'd0});

  always_ff @(posedge clk) begin
    if (en) begin
      m6200 <= 30'(alux_pkg::C0_P) * 30'(pwr);
      dlin2 <= (lin_add > lin_sub) ? 28'(lin_add - lin_sub) : 28'd0;
      b2 <= b_p;
      region2 <= region_p;

      prod0 <= 46'(m6200) * 46'(b2);
      dlin3 <= dlin2;
      b3 <= b2;
      region3 <= region2;

      if (region3 == alux_pkg::REGION_0) begin
        diff4 <= (add0 > prod0) ? 44'(add0 - prod0) : 44'd0;
      end else begin
        diff4 <= 44'(dlin3);
      end
      region4 <= region3;

      value5 <= 57'(diff4) * 57'(num_s);
      den5 <= den_s;
      region5 <= region4;

      sat6 <= (num_r >= den_top);
      num6 <= NW2'(num_r);
      den6 <= den5;
      region6 <= region5;
    end
  end

  logic        dv2_valid;
  logic [31:0] q2;
  logic [3:0]  dv2_pay;
  alux_div #(.QW(32), .DW(DW2), .PW(4)) u_lux_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .num(num6), .den(den6), .in_pay({sat6, region6}),
    .out_valid(dv2_valid), .quot(q2), .out_pay(dv2_pay)
  );

  // S7: final select into output buffer
  logic [31:0] lux_f;
  always_comb begin
    if (dv2_pay[2:0] == alux_pkg::REGION_NONE) lux_f = 32'd0;
    else if (dv2_pay[3]) lux_f = 32'hFFFF_FFFF;
    else lux_f = q2;
  end

  alux_ofifo u_ofifo (
    .clk(clk), .rst(rst),
    .push(en && dv2_valid), .push_lux(lux_f), .push_region(dv2_pay[2:0]),
    .full(full), .result(result)
  );

endmodule

FILE: rtl/alux_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees the quotient fits in QW bits.
module alux_div #(
  parameter int unsigned QW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned PW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  input  logic [PW-1:0]    in_pay,
  output logic             out_valid,
  output logic [QW-1:0]    quot,
  output logic [PW-1:0]    out_pay
);

  logic          v_r   [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   trial;
    logic          qbit;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = num[QW+DW-1:QW];
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign pay_in = in_pay;
    end else begin : g_next
      assign v_in = v_r[i-1];
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign den_in = den_r[i-1];
      assign pay_in = pay_r[i-1];
    end

    // shift in next numerator bit and try subtract
    assign trial = {rem_in, low_in[QW-1]};
    assign qbit = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= qbit ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_r[i] <= {low_in[QW-2:0], qbit};
        den_r[i] <= den_in;
        pay_r[i] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot = low_r[QW-1];
  assign out_pay = pay_r[QW-1];

endmodule

FILE: rtl/alux_power.sv
// Ratio power term: table lookup and linear interpolation, three stages.
module alux_power #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [$clog2(DEPTH+1)+15:0] pos,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [16:0]     pwr,
  output logic [PW-1:0]   out_pay
);

  localparam int unsigned IW = $clog2(DEPTH+1);
  localparam logic [63:0] D2 = 64'(2 * DEPTH);
  localparam logic [63:0] BASE = (64'd1 << 60) / D2;
  localparam logic [63:0] RM = (64'd1 << 60) % D2;
  localparam logic [63:0] TDEN = D2 << 8;

  // (k/(2*DEPTH))^1.4 in Q0.16, via x * fifth_root(x)^2
  function automatic logic [16:0] pow_entry(input logic [63:0] k);
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] m5;
    logic [63:0] e;
    t = BASE * k + (RM * k) / D2;
    lo = 64'd0;
    hi = 64'd4096;
    for (int n = 0; n < 16; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        m5 = mid * mid * mid * mid * mid;
        if (m5 <= t) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    e = (k * lo * lo + (TDEN >> 1)) / TDEN;
    return e[16:0];
  endfunction

  logic [16:0] tab [DEPTH+1];
  for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
    assign tab[g] = pow_entry(64'(g));
  end

  // index and fraction, clamped at the last point
  logic [IW-1:0] idx;
  logic [IW-1:0] idx1;
  logic [15:0]   frac;
  always_comb begin
    idx = pos[IW+15:16];
    frac = pos[15:0];
    if (idx >= IW'(DEPTH)) begin
      idx = IW'(DEPTH);
      frac = 16'd0;
    end
    idx1 = (idx == IW'(DEPTH)) ? idx : IW'(idx + 1'b1);
  end

  logic          v1, v2, v3;
  logic [16:0]   p0_1, p1_1, p0_2;
  logic [15:0]   frac_1;
  logic [32:0]   prod_2;
  logic [PW-1:0] pay1, pay2, pay3;
  logic [16:0]   p_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // table read
      p0_1 <= tab[idx];
      p1_1 <= tab[idx1];
      frac_1 <= frac;
      pay1 <= in_pay;
      // slope times fraction
      prod_2 <= 33'(p1_1 - p0_1) * 33'(frac_1);
      p0_2 <= p0_1;
      pay2 <= pay1;
      // interpolated value, floored
      p_3 <= 17'(p0_2 + prod_2[32:16]);
      pay3 <= pay2;
    end
  end

  assign out_valid = v3;
  assign pwr = p_3;
  assign out_pay = pay3;

endmodule

FILE: rtl/alux_ofifo.sv
// Two-entry output buffer; full flag is registered state.
module alux_ofifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_lux,
  input  logic [2:0]  push_region,
  output logic        full,
  alux_result_if.source result
);

  logic [31:0] lux_mem [2];
  logic [2:0]  reg_mem [2];
  logic        wptr, rptr;
  logic [1:0]  count, count_next;
  logic        pop;

  assign pop = result.valid && result.ready;
  assign result.valid = (count != 2'd0);
  assign result.lux_value = lux_mem[rptr];
  assign result.region = reg_mem[rptr];
  assign full = (count == 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = 2'(count + 1'b1);
    end else if (!push && pop) begin
      count_next = 2'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      lux_mem[wptr] <= push_lux;
      reg_mem[wptr] <= push_region;
    end
  end

endmodule
